// ===== rtl/core/ihm_pkg.sv =====
// Shared constants and codes for the integer hash map.
`default_nettype none
package ihm_pkg;

  localparam int SLOTS_DEFAULT = 1024;

  localparam logic [31:0] PHI_MULT  = 32'h9E37_79B9;
  localparam int          MIX_SHIFT = 16;

  localparam logic [4:0]  SIZE_LOG2_RESET   = 5'd10;
  localparam logic [15:0] MAX_ENTRIES_RESET = 16'd768;

  // register index, taken from paddr[2]
  localparam logic REG_SIZE_LOG2   = 1'b0;
  localparam logic REG_MAX_ENTRIES = 1'b1;

  // request kinds
  localparam logic KIND_GET = 1'b0;
  localparam logic KIND_PUT = 1'b1;

  // result status codes
  localparam logic [2:0] ST_MISS     = 3'd0;
  localparam logic [2:0] ST_HIT      = 3'd1;
  localparam logic [2:0] ST_INSERTED = 3'd2;
  localparam logic [2:0] ST_UPDATED  = 3'd3;
  localparam logic [2:0] ST_FULL     = 3'd4;

endpackage
`default_nettype wire

// ===== rtl/core/ihm_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module ihm_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== rtl/core/int_hash_map_linear_probe.sv =====
// Integer hash map with open addressing and linear probing (top level).
//
// One request is in flight at a time. A get or put of a nonzero key is
// registered at acceptance, hashed in S_HASH while its home slot is read,
// and checked in S_CHECK, one slot per cycle, until a hit, an empty slot or
// the last slot in use settles it. Key zero lives in its own register pair
// and is settled at acceptance. The next request is taken while a result
// still waits in the output register. After reset a clearing pass zeroes
// every slot of the slot RAM; no request is taken during it, register writes are.
`default_nettype none
module int_hash_map_linear_probe #(
  parameter int SLOTS = ihm_pkg::SLOTS_DEFAULT
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // request stream
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [63:0] s_tdata,   // [31:0] key, [63:32] value
  input  wire logic        s_tuser,   // [0] kind: 0 get, 1 put
  // result stream
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic      [39:0] m_tdata,   // [31:0] result_value, [34:32] status, pad
  // configuration
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready
);

  import ihm_pkg::*;

  localparam int AW = $clog2(SLOTS);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_HASH,
    S_CHECK,
    S_DONE
  } state_t;

  state_t state;

  logic [4:0]    size_log2;
  logic [15:0]   max_entries;
  logic [16:0]   entry_count;
  logic          zero_key_present;
  logic [31:0]   zero_key_value;

  logic          kind_r;
  logic [31:0]   key_r;
  logic [31:0]   val_r;
  logic [31:0]   prod;
  logic [AW-1:0] pos;
  logic [AW-1:0] n;
  logic [AW-1:0] clr_addr;
  logic [31:0]   res_r;
  logic [2:0]    st_r;

  logic [4:0]    lg;
  logic [AW-1:0] mask;
  logic [31:0]   mixed;
  logic [AW-1:0] home;
  logic [AW-1:0] pos_inc;
  logic          full;
  logic          out_free;
  logic          out_load;
  logic          accept;
  logic          cfg_we;

  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [63:0]   mem_wdata;
  logic [AW-1:0] mem_raddr;
  logic [63:0]   mem_rdata;

  logic [31:0]   slot_key;
  logic [31:0]   slot_val;
  logic          chk_hit;
  logic          chk_empty;
  logic          chk_last;

  logic          fin;
  logic [31:0]   fin_res;
  logic [2:0]    fin_st;

  ihm_ram #(
    .WIDTH(64),
    .DEPTH(SLOTS)
  ) u_slots (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  assign pready   = 1'b1;
  assign cfg_we   = psel & penable & pwrite;
  assign prdata   = (paddr[2] == REG_MAX_ENTRIES) ? {16'd0, max_entries} : {27'd0, size_log2};

  assign s_tready = (state == S_IDLE);
  assign accept   = s_tvalid & s_tready;
  assign out_free = ~m_tvalid | m_tready;
  assign out_load = out_free & (fin | (state == S_DONE));
  assign full     = (entry_count >= {1'b0, max_entries});

  // slots in use: 2^size_log2, at least 2, at most SLOTS
  assign lg = (size_log2 == 5'd0) ? 5'd1 : size_log2;
  always_comb begin
    for (int i = 0; i < AW; i++) begin
      mask[i] = (5'(i) < lg);
    end
  end

  assign mixed   = prod ^ (prod >> MIX_SHIFT);
  assign home    = mixed[AW-1:0] & mask;
  assign pos_inc = AW'(pos + AW'(1)) & mask;

  assign slot_key  = mem_rdata[31:0];
  assign slot_val  = mem_rdata[63:32];
  assign chk_hit   = (slot_key == key_r);
  assign chk_empty = (slot_key == 32'd0);
  assign chk_last  = (n == mask);

  always_comb begin
    mem_raddr = (state == S_HASH) ? home : pos_inc;
    mem_waddr = (state == S_CLEAR) ? clr_addr : pos;
    mem_wdata = (state == S_CLEAR) ? 64'd0 : {val_r, key_r};
    mem_we    = 1'b0;
    case (state)
      S_CLEAR: mem_we = 1'b1;
      S_CHECK: mem_we = (kind_r == KIND_PUT) & (chk_hit | (chk_empty & ~full));
      default: mem_we = 1'b0;
    endcase
  end

  // end of a request: zero key at acceptance, or a settled probe
  always_comb begin
    fin     = 1'b0;
    fin_res = 32'd0;
    fin_st  = ST_MISS;
    case (state)
      S_IDLE: begin
        if (accept && s_tdata[31:0] == 32'd0) begin
          fin = 1'b1;
          if (s_tuser == KIND_GET) begin
            if (zero_key_present) begin
              fin_res = zero_key_value;
              fin_st  = ST_HIT;
            end
          end else if (zero_key_present) begin
            fin_res = zero_key_value;
            fin_st  = ST_UPDATED;
          end else if (full) begin
            fin_st = ST_FULL;
          end else begin
            fin_st = ST_INSERTED;
          end
        end
      end
      S_CHECK: begin
        if (chk_hit) begin
          fin     = 1'b1;
          fin_res = slot_val;
          fin_st  = (kind_r == KIND_PUT) ? ST_UPDATED : ST_HIT;
        end else if (chk_empty) begin
          fin = 1'b1;
          if (kind_r == KIND_PUT) begin
            fin_st = full ? ST_FULL : ST_INSERTED;
          end
        end else if (chk_last) begin
          fin    = 1'b1;
          fin_st = (kind_r == KIND_PUT) ? ST_FULL : ST_MISS;
        end
      end
      default: begin
        fin = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_CLEAR;
      clr_addr         <= '0;
      size_log2        <= SIZE_LOG2_RESET;
      max_entries      <= MAX_ENTRIES_RESET;
      entry_count      <= '0;
      zero_key_present <= 1'b0;
      zero_key_value   <= '0;
      m_tvalid         <= 1'b0;
    end else begin
      if (cfg_we) begin
        if (paddr[2] == REG_SIZE_LOG2) begin
          size_log2 <= pwdata[4:0];
        end else begin
          max_entries <= pwdata[15:0];
        end
      end

      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end

      if (fin) begin
        if (out_free) begin
          m_tdata  <= {5'd0, fin_st, fin_res};
          state    <= S_IDLE;
        end else begin
          res_r <= fin_res;
          st_r  <= fin_st;
          state <= S_DONE;
        end
        if (fin_st == ST_INSERTED) begin
          entry_count <= entry_count + 17'd1;
        end
      end

      case (state)
        S_CLEAR: begin
          clr_addr <= AW'(clr_addr + AW'(1));
          if (clr_addr == AW'(SLOTS - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            kind_r <= s_tuser;
            key_r  <= s_tdata[31:0];
            val_r  <= s_tdata[63:32];
            prod   <= s_tdata[31:0] * PHI_MULT;
            if (s_tdata[31:0] == 32'd0) begin
              if (s_tuser == KIND_PUT && (zero_key_present || !full)) begin
                zero_key_present <= 1'b1;
                zero_key_value   <= s_tdata[63:32];
              end
            end else begin
              state <= S_HASH;
            end
          end
        end
        S_HASH: begin
          pos   <= home;
          n     <= '0;
          state <= S_CHECK;
        end
        S_CHECK: begin
          if (!fin) begin
            pos <= pos_inc;
            n   <= AW'(n + AW'(1));
          end
        end
        S_DONE: begin
          if (out_free) begin
            m_tdata  <= {5'd0, st_r, res_r};
            state    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire
